@@ rtl/core/vqa_pkg.sv @@
// Shared types and constants for the vector-to-quadrant angle block.
// No dependencies; every other file refers to this package by scoped names.
package vqa_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ITERATIONS  = 16;

  // Datapath widths: magnitude shifted left by the guard bits, plus growth headroom.
  localparam int GUARD_GROW  = 3;
  localparam int XW          = COORD_WIDTH + ITERATIONS + GUARD_GROW;
  localparam int ZW          = 21;
  localparam int ANGLE_WIDTH = 15;
  localparam int TABLE_LEN   = 24;

  localparam logic signed [ZW-1:0]          HALF_PI_18 = 21'sd411775;
  localparam logic        [ANGLE_WIDTH-1:0] HALF_PI_14 = 15'd25736;

  // atan(2^-i) in radians, 18 fraction bits, rounded to nearest.
  localparam logic [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    21'd205887, 21'd121542, 21'd64220, 21'd32599, 21'd16363, 21'd8189,
    21'd4096,   21'd2048,   21'd1024,  21'd512,   21'd256,   21'd128,
    21'd64,     21'd32,     21'd16,    21'd8,     21'd4,     21'd2,
    21'd1,      21'd0,      21'd0,     21'd0,     21'd0,     21'd0
  };

  typedef enum logic [1:0] {
    QUAD_NORTH = 2'd0,
    QUAD_EAST  = 2'd1,
    QUAD_SOUTH = 2'd2,
    QUAD_WEST  = 2'd3
  } quad_t;

  // Side information that rides along with each vector through the pipeline.
  typedef struct packed {
    quad_t quad;
    logic  zero_vec;
    logic  den_zero;
    logic  num_zero;
  } side_t;

endpackage

@@ rtl/core/vqa_cordic_pipe.sv @@
// Unrolled CORDIC vectoring pipeline, one register stage per iteration.
// Depends on vqa_pkg for widths, the arctangent table and the side-info struct.
module vqa_cordic_pipe (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  vqa_pkg::side_t                  in_side,
  input  logic signed [vqa_pkg::XW-1:0]   in_x,
  input  logic signed [vqa_pkg::XW-1:0]   in_y,
  output logic                            out_valid,
  output vqa_pkg::side_t                  out_side,
  output logic signed [vqa_pkg::ZW-1:0]   out_z
);

  localparam int N = vqa_pkg::ITERATIONS;

  logic                          valid_r [N];
  vqa_pkg::side_t                side_r  [N];
  logic signed [vqa_pkg::XW-1:0] x_r     [N];
  logic signed [vqa_pkg::XW-1:0] y_r     [N];
  logic signed [vqa_pkg::ZW-1:0] z_r     [N];

  logic signed [vqa_pkg::XW-1:0] x_nxt   [N];
  logic signed [vqa_pkg::XW-1:0] y_nxt   [N];
  logic signed [vqa_pkg::ZW-1:0] z_nxt   [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_iter
      logic                          v_in;
      vqa_pkg::side_t                s_in;
      logic signed [vqa_pkg::XW-1:0] x_in;
      logic signed [vqa_pkg::XW-1:0] y_in;
      logic signed [vqa_pkg::ZW-1:0] z_in;
      logic signed [vqa_pkg::XW-1:0] dx;
      logic signed [vqa_pkg::XW-1:0] dy;
      logic signed [vqa_pkg::ZW-1:0] step;

      if (i == 0) begin : g_first
        assign v_in = in_valid;
        assign s_in = in_side;
        assign x_in = in_x;
        assign y_in = in_y;
        assign z_in = '0;
      end else begin : g_rest
        assign v_in = valid_r[i-1];
        assign s_in = side_r[i-1];
        assign x_in = x_r[i-1];
        assign y_in = y_r[i-1];
        assign z_in = z_r[i-1];
      end

      // Floor shifts; rotate toward y = 0.
      assign dx   = y_in >>> i;
      assign dy   = x_in >>> i;
      assign step = $signed(vqa_pkg::ATAN_TAB[i]);

      assign x_nxt[i] = y_in[vqa_pkg::XW-1] ? (x_in - dx) : (x_in + dx);
      assign y_nxt[i] = y_in[vqa_pkg::XW-1] ? (y_in + dy) : (y_in - dy);
      assign z_nxt[i] = y_in[vqa_pkg::XW-1] ? (z_in - step) : (z_in + step);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[i] <= 1'b0;
        end else begin
          valid_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        side_r[i] <= s_in;
        x_r[i]    <= x_nxt[i];
        y_r[i]    <= y_nxt[i];
        z_r[i]    <= z_nxt[i];
      end
    end
  endgenerate

  assign out_valid = valid_r[N-1];
  assign out_side  = side_r[N-1];
  assign out_z     = z_r[N-1];

endmodule

@@ rtl/core/vector_to_quadrant_angle.sv @@
// Compass quadrant and in-quadrant angle of a signed 2D vector (CORDIC vectoring).
// Depends on vqa_pkg and vqa_cordic_pipe.
// Pipeline from the start transfer to the out_valid strobe: input register, prep
// stage, one stage per CORDIC iteration, output stage. Throughput: one vector per
// cycle; busy is always low.
// Reset (synchronous, rst_n low) clears all valid bits; no result is in flight after it.
module vector_to_quadrant_angle (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [vqa_pkg::COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [vqa_pkg::COORD_WIDTH-1:0] in_vec_y,
  output logic                                out_valid,
  output logic        [1:0]                   out_quadrant,
  output logic        [vqa_pkg::ANGLE_WIDTH-1:0] out_angle,
  output logic                                out_zero_vector
);

  localparam int CW  = vqa_pkg::COORD_WIDTH;
  localparam int XW  = vqa_pkg::XW;
  localparam int ZW  = vqa_pkg::ZW;
  localparam int AW  = vqa_pkg::ANGLE_WIDTH;
  localparam int PAD = XW - CW - vqa_pkg::ITERATIONS;
  localparam int CZW = ZW - 1;

  // The pipeline advances every cycle and the receiver cannot stall,
  // so there is never a reason to hold off a transfer.
  assign busy = 1'b0;

  // ---------------------------------------------------------------
  // Stage A: capture the input transfer.
  // ---------------------------------------------------------------
  logic                 a_valid_r;
  logic signed [CW-1:0] a_x_r;
  logic signed [CW-1:0] a_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a_x_r <= in_vec_x;
    a_y_r <= in_vec_y;
  end

  // ---------------------------------------------------------------
  // Stage B: quadrant from the signs, magnitudes, dividend/divisor pick.
  // ---------------------------------------------------------------
  logic            x_pos;
  logic            y_pos;
  logic [CW-1:0]   ax;
  logic [CW-1:0]   ay;
  logic [CW-1:0]   num;
  logic [CW-1:0]   den;
  vqa_pkg::side_t  side_nxt;

  always_comb begin
    x_pos = ~a_x_r[CW-1] & (|a_x_r);
    y_pos = ~a_y_r[CW-1] & (|a_y_r);
    // Negating the most negative value wraps to 2^(CW-1), which is the right magnitude.
    ax = a_x_r[CW-1] ? (~a_x_r + CW'(1)) : a_x_r;
    ay = a_y_r[CW-1] ? (~a_y_r + CW'(1)) : a_y_r;

    if (x_pos) begin
      side_nxt.quad = y_pos ? vqa_pkg::QUAD_EAST : vqa_pkg::QUAD_NORTH;
    end else begin
      side_nxt.quad = y_pos ? vqa_pkg::QUAD_SOUTH : vqa_pkg::QUAD_WEST;
    end

    // North and south divide |x| by |y|; east and west divide |y| by |x|.
    if (side_nxt.quad == vqa_pkg::QUAD_NORTH || side_nxt.quad == vqa_pkg::QUAD_SOUTH) begin
      num = ax;
      den = ay;
    end else begin
      num = ay;
      den = ax;
    end

    side_nxt.num_zero = ~(|num);
    side_nxt.den_zero = ~(|den);
    side_nxt.zero_vec = side_nxt.num_zero & side_nxt.den_zero;
  end

  logic                 b_valid_r;
  vqa_pkg::side_t       b_side_r;
  logic signed [XW-1:0] b_x_r;
  logic signed [XW-1:0] b_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  // Start the rotation at (den, num), each shifted up by the guard bits.
  always_ff @(posedge clk) begin
    b_side_r <= side_nxt;
    b_x_r    <= $signed({{PAD{1'b0}}, den, {vqa_pkg::ITERATIONS{1'b0}}});
    b_y_r    <= $signed({{PAD{1'b0}}, num, {vqa_pkg::ITERATIONS{1'b0}}});
  end

  // ---------------------------------------------------------------
  // CORDIC iterations, one register stage each.
  // ---------------------------------------------------------------
  logic                 c_valid;
  vqa_pkg::side_t       c_side;
  logic signed [ZW-1:0] c_z;

  vqa_cordic_pipe u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid_r),
    .in_side   (b_side_r),
    .in_x      (b_x_r),
    .in_y      (b_y_r),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_z     (c_z)
  );

  // ---------------------------------------------------------------
  // Output stage: clamp to 0 .. pi/2, round to 14 fraction bits,
  // then apply the zero-divisor / zero-dividend overrides.
  // ---------------------------------------------------------------
  logic [CZW-1:0] z_clamp;
  logic [CZW-1:0] z_round;
  logic [AW-1:0]  ang_round;
  logic [AW-1:0]  angle_nxt;

  always_comb begin
    if (c_z[ZW-1]) begin
      z_clamp = '0;
    end else if (c_z > vqa_pkg::HALF_PI_18) begin
      z_clamp = vqa_pkg::HALF_PI_18[CZW-1:0];
    end else begin
      z_clamp = c_z[CZW-1:0];
    end

    z_round = z_clamp + CZW'(8);

    if (z_round[CZW-1:4] > (CZW-4)'(vqa_pkg::HALF_PI_14)) begin
      ang_round = vqa_pkg::HALF_PI_14;
    end else begin
      ang_round = z_round[AW+3:4];
    end

    if (c_side.zero_vec) begin
      angle_nxt = '0;
    end else if (c_side.den_zero) begin
      angle_nxt = vqa_pkg::HALF_PI_14;
    end else if (c_side.num_zero) begin
      angle_nxt = '0;
    end else begin
      angle_nxt = ang_round;
    end
  end

  logic          out_valid_r;
  logic [1:0]    out_quadrant_r;
  logic [AW-1:0] out_angle_r;
  logic          out_zero_vector_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_quadrant_r    <= c_side.quad;
    out_angle_r       <= angle_nxt;
    out_zero_vector_r <= c_side.zero_vec;
  end

  assign out_valid       = out_valid_r;
  assign out_quadrant    = out_quadrant_r;
  assign out_angle       = out_angle_r;
  assign out_zero_vector = out_zero_vector_r;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for vector_to_quadrant_angle: directed table, then random vectors.
// Depends on vqa_pkg and the vector_to_quadrant_angle RTL; predicts each result in place.
module testbench;

  localparam int CW = vqa_pkg::COORD_WIDTH;
  localparam int AW = vqa_pkg::ANGLE_WIDTH;

  // Pipeline depth given in the block's header: input reg, prep, one stage per iteration, output.
  localparam int PIPE_LATENCY   = vqa_pkg::ITERATIONS + 3;
  localparam int CORDIC_STEPS   = vqa_pkg::ITERATIONS;
  localparam int RANDOM_VECTORS = 2000;
  // Cycles without any transfer on either side before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  // Angles in radians: quarter turn at 18 and at 14 fraction bits.
  localparam longint QUARTER_TURN_Q18 = 411775;
  localparam longint QUARTER_TURN_Q14 = 25736;

  // atan(2^-i), 18 fraction bits, rounded to nearest.
  localparam longint ARCTAN_STEP [24] = '{
    205887, 121542, 64220, 32599, 16363, 8189, 4096, 2048,
    1024, 512, 256, 128, 64, 32, 16, 8,
    4, 2, 1, 0, 0, 0, 0, 0
  };

  typedef struct {
    vqa_pkg::quad_t quadrant;
    logic [AW-1:0]  angle;
    logic           zero_vector;
  } heading_t;

  // One row of the directed part; has_expect marks rows whose result is typed in.
  typedef struct {
    int             x;
    int             y;
    bit             has_expect;
    vqa_pkg::quad_t quadrant;
    logic [AW-1:0]  angle;
    logic           zero_vector;
  } heading_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_vec_x = '0;
  logic signed [CW-1:0] in_vec_y = '0;
  logic                 out_valid;
  logic [1:0]           out_quadrant;
  logic [AW-1:0]        out_angle;
  logic                 out_zero_vector;

  heading_t pending_headings[$];
  int       mismatch_count = 0;
  int       accepted_vectors = 0;
  int       quiet_cycles = 0;

  // Typed-in expectation for the vector currently on the input ports.
  bit       row_has_expect = 1'b0;
  heading_t row_expect;

  always #4 clk = ~clk;

  vector_to_quadrant_angle i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_vec_x        (in_vec_x),
    .in_vec_y        (in_vec_y),
    .out_valid       (out_valid),
    .out_quadrant    (out_quadrant),
    .out_angle       (out_angle),
    .out_zero_vector (out_zero_vector)
  );

  // Quadrant from the signs, then a vectoring CORDIC on the magnitudes with guard bits.
  function automatic heading_t predict_heading(input logic signed [CW-1:0] vx,
                                               input logic signed [CW-1:0] vy);
    heading_t h;
    longint   sx, sy, mag_x, mag_y, dividend, divisor;
    longint   cx, cy, cz, step_x, step_y;
    sx    = longint'(vx);
    sy    = longint'(vy);
    mag_x = (sx < 0) ? -sx : sx;
    mag_y = (sy < 0) ? -sy : sy;
    if (sx > 0) begin
      h.quadrant = (sy > 0) ? vqa_pkg::QUAD_EAST : vqa_pkg::QUAD_NORTH;
    end else begin
      h.quadrant = (sy > 0) ? vqa_pkg::QUAD_SOUTH : vqa_pkg::QUAD_WEST;
    end
    // North and south measure from the y axis, east and west from the x axis.
    if (h.quadrant == vqa_pkg::QUAD_NORTH || h.quadrant == vqa_pkg::QUAD_SOUTH) begin
      dividend = mag_x;
      divisor  = mag_y;
    end else begin
      dividend = mag_y;
      divisor  = mag_x;
    end
    h.zero_vector = 1'b0;
    if (dividend == 0 && divisor == 0) begin
      h.angle       = '0;
      h.zero_vector = 1'b1;
    end else if (divisor == 0) begin
      h.angle = QUARTER_TURN_Q14[AW-1:0];
    end else if (dividend == 0) begin
      h.angle = '0;
    end else begin
      cx = divisor << CORDIC_STEPS;
      cy = dividend << CORDIC_STEPS;
      cz = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        // Arithmetic shifts on signed longint floor toward minus infinity.
        step_x = cy >>> i;
        step_y = cx >>> i;
        if (cy >= 0) begin
          cx = cx + step_x;
          cy = cy - step_y;
          cz = cz + ARCTAN_STEP[i];
        end else begin
          cx = cx - step_x;
          cy = cy + step_y;
          cz = cz - ARCTAN_STEP[i];
        end
      end
      if (cz < 0) cz = 0;
      if (cz > QUARTER_TURN_Q18) cz = QUARTER_TURN_Q18;
      cz = (cz + 8) >>> 4;
      if (cz > QUARTER_TURN_Q14) cz = QUARTER_TURN_Q14;
      h.angle = cz[AW-1:0];
    end
    return h;
  endfunction

  // Check results first, then log the transfer on the input side; sample on the rising edge.
  always @(posedge clk) begin
    heading_t want;
    bit       active;
    active = 1'b0;
    if (rst_n && out_valid) begin
      active = 1'b1;
      if (pending_headings.size() == 0) begin
        $error("unexpected result: quadrant %0d angle %0d zero_vector %0d",
               out_quadrant, out_angle, out_zero_vector);
        mismatch_count++;
      end else begin
        want = pending_headings.pop_front();
        if (out_quadrant !== want.quadrant) begin
          $error("quadrant: expected %0d, got %0d", want.quadrant, out_quadrant);
          mismatch_count++;
        end
        if (out_angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, out_angle);
          mismatch_count++;
        end
        if (out_zero_vector !== want.zero_vector) begin
          $error("zero_vector: expected %0d, got %0d", want.zero_vector, out_zero_vector);
          mismatch_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      active = 1'b1;
      if (row_has_expect) begin
        pending_headings.push_back(row_expect);
      end else begin
        pending_headings.push_back(predict_heading(in_vec_x, in_vec_y));
      end
      accepted_vectors++;
    end
    // Watchdog: restart on any transfer, give up after a long silence.
    if (active) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Present one vector at the falling edge and hold it until the transfer happens.
  task automatic send_vector(input logic signed [CW-1:0] vx,
                             input logic signed [CW-1:0] vy);
    int seen;
    seen = accepted_vectors;
    start    <= 1'b1;
    in_vec_x <= vx;
    in_vec_y <= vy;
    do @(negedge clk); while (accepted_vectors == seen);
  endtask

  // Bursts of random length, separated by random gaps; some bursts run back to back.
  int burst_left = 0;
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        // Drop start and put noise on the data while idle.
        start    <= 1'b0;
        in_vec_x <= CW'($urandom);
        in_vec_y <= CW'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  function automatic logic signed [CW-1:0] extreme_coord();
    case ($urandom_range(0, 5))
      0:       return CW'(-32768);
      1:       return CW'(-32767);
      2:       return CW'(-1);
      3:       return '0;
      4:       return CW'(1);
      default: return CW'(32767);
    endcase
  endfunction

  heading_row_t heading_table [23];

  initial begin
    logic signed [CW-1:0] vx, vy;
    int                   delta;

    // Typed rows: zero vector, zero divisor, zero dividend. The rest go through the predictor.
    heading_table = '{
      '{0,      0,      1'b1, vqa_pkg::QUAD_WEST,  15'd0,     1'b1},
      '{5,      0,      1'b1, vqa_pkg::QUAD_NORTH, 15'd25736, 1'b0},
      '{0,      5,      1'b1, vqa_pkg::QUAD_SOUTH, 15'd0,     1'b0},
      '{-5,     0,      1'b1, vqa_pkg::QUAD_WEST,  15'd0,     1'b0},
      '{0,      -5,     1'b1, vqa_pkg::QUAD_WEST,  15'd25736, 1'b0},
      '{-32768, 0,      1'b1, vqa_pkg::QUAD_WEST,  15'd0,     1'b0},
      '{0,      -32768, 1'b1, vqa_pkg::QUAD_WEST,  15'd25736, 1'b0},
      '{32767,  0,      1'b1, vqa_pkg::QUAD_NORTH, 15'd25736, 1'b0},
      '{0,      32767,  1'b1, vqa_pkg::QUAD_SOUTH, 15'd0,     1'b0},
      '{-32768, -32768, 1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{32767,  32767,  1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-32768, 32767,  1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{32767,  -32768, 1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{1,      -32768, 1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-32768, 1,      1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-1,     -32768, 1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-32768, -1,     1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{1,      1,      1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-1,     -1,     1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{1,      -1,     1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{-1,     1,      1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{3,      4,      1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0},
      '{12345,  -23456, 1'b0, vqa_pkg::QUAD_NORTH, 15'd0,     1'b0}
    };

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (heading_table[r]) begin
      pace_sender();
      row_has_expect         = heading_table[r].has_expect;
      row_expect.quadrant    = heading_table[r].quadrant;
      row_expect.angle       = heading_table[r].angle;
      row_expect.zero_vector = heading_table[r].zero_vector;
      send_vector(CW'(heading_table[r].x), CW'(heading_table[r].y));
    end
    row_has_expect = 1'b0;

    for (int n = 0; n < RANDOM_VECTORS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          vx = CW'($urandom);
          vy = CW'($urandom);
        end
        4: begin
          vx = CW'($signed($urandom_range(0, 16)) - 8);
          vy = CW'($signed($urandom_range(0, 16)) - 8);
        end
        5: begin
          // Land on an axis: one component zero.
          vx = CW'($urandom);
          vy = '0;
          if ($urandom_range(0, 1)) begin
            vy = vx;
            vx = '0;
          end
        end
        6, 7: begin
          // Near the diagonal, where the CORDIC has to settle around pi/4.
          vx    = CW'($urandom);
          delta = $signed($urandom_range(0, 8)) - 4;
          vy    = CW'($urandom_range(0, 1) ? vx + delta : -vx + delta);
        end
        8: begin
          vx = extreme_coord();
          vy = extreme_coord();
        end
        default: begin
          // Very unequal magnitudes: angles close to 0 or pi/2.
          vx = CW'($urandom);
          vy = CW'($signed($urandom_range(0, 6)) - 3);
          if ($urandom_range(0, 1)) begin
            vy = vx;
            vx = CW'($signed($urandom_range(0, 6)) - 3);
          end
        end
      endcase
      pace_sender();
      send_vector(vx, vy);
    end

    start <= 1'b0;
    while (pending_headings.size() != 0) @(negedge clk);
    // Let any stray strobe show up before the verdict.
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
